FILE: src/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types, constants and register codes of the debounced position
// change counter.
// ----------------------------------------------------------------------------
package dpc_pkg;

    // Timer and counter widths.
    localparam int TIMER_BITS = 16;
    localparam int COUNT_BITS = 8;

    // Field widths fixed by the interface.
    localparam int CFG_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int SLOT_BITS     = 3;
    localparam int MOVES_BITS    = 8;
    localparam int S_TDATA_BITS  = 8;
    localparam int M_TDATA_BITS  = 24;
    localparam int M_TDATA_USED  = 17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUICK_TURN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLDOFF    = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = 16'd200;
    localparam logic [CFG_BITS-1:0] QUICK_TURN_RESET = 16'd1500;
    localparam logic [CFG_BITS-1:0] HOLDOFF_RESET    = 16'd10000;

    // Slot decode: position bits plus three per wheel plus one.
    localparam logic [SLOT_BITS-1:0] WHEEL_SLOT_STEP = 3'd3;
    localparam logic [SLOT_BITS-1:0] SLOT_BASE       = 3'd1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_COUNT    = 3'd2,
        PH_WAIT     = 3'd3,
        PH_DETECTED = 3'd4
    } t_phase;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_CLEAR = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [CFG_BITS-1:0] debounce_ms;
        logic [CFG_BITS-1:0] quick_turn_ms;
        logic [CFG_BITS-1:0] startup_holdoff_ms;
    } t_cfg;

    typedef struct packed {
        logic [SLOT_BITS-1:0]  slot_index;
        logic                  is_am;
        logic                  wheel_now;
        logic                  detected;
        logic [MOVES_BITS-1:0] moves_counted;
        t_phase                phase;
    } t_result;

endpackage

FILE: src/dpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dpc_cfg_regs
// Configuration register file: debounce, quick turn and startup hold-off.
// ----------------------------------------------------------------------------
module dpc_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [dpc_pkg::CFG_IDX_BITS-1:0]   i_index,
    input  logic [dpc_pkg::CFG_BITS-1:0]       i_data,
    output dpc_pkg::t_cfg                      o_cfg
);

    dpc_pkg::t_cfg r_cfg;

    // Writes to an index beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= dpc_pkg::DEBOUNCE_RESET;
            r_cfg.quick_turn_ms      <= dpc_pkg::QUICK_TURN_RESET;
            r_cfg.startup_holdoff_ms <= dpc_pkg::HOLDOFF_RESET;
        end else if (i_wr_en) begin
            case (i_index)
                dpc_pkg::REG_DEBOUNCE:   r_cfg.debounce_ms        <= i_data;
                dpc_pkg::REG_QUICK_TURN: r_cfg.quick_turn_ms      <= i_data;
                dpc_pkg::REG_HOLDOFF:    r_cfg.startup_holdoff_ms <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/dpc_core.sv
// ----------------------------------------------------------------------------
// dpc_core
// Sensor decode, change detection, phase machine and timers. State moves on
// each accepted word; the result reflects the state after that word.
// ----------------------------------------------------------------------------
module dpc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_opcode,
    input  logic            i_wheel_raw,
    input  logic            i_am_raw,
    input  logic            i_bit_one_raw,
    input  logic            i_bit_two_raw,
    input  dpc_pkg::t_cfg   i_cfg,
    output dpc_pkg::t_result o_result
);

    localparam logic [dpc_pkg::TIMER_BITS-1:0] TIMER_ZERO = '0;
    localparam logic [dpc_pkg::COUNT_BITS-1:0] COUNT_ZERO = '0;

    dpc_pkg::t_phase r_phase, n_phase;
    logic [dpc_pkg::TIMER_BITS-1:0] r_quiet, n_quiet, r_uptime, n_uptime;
    logic [dpc_pkg::TIMER_BITS-1:0] quiet_inc, uptime_inc;
    logic [dpc_pkg::COUNT_BITS-1:0] r_move_count, n_move_count, count_inc;
    logic [dpc_pkg::SLOT_BITS-1:0]  r_prev_slot, n_prev_slot;
    logic                           r_prev_am, n_prev_am, r_prev_wheel, n_prev_wheel;

    logic                           wheel, am, bit_one, bit_two;
    logic [dpc_pkg::SLOT_BITS-1:0]  slot;
    logic                           is_clear, is_tick;
    logic                           past_holdoff, wheel_diff, am_diff, slot_diff, change;
    logic                           debounce_done, quick_done;
    logic [31:0]                    count_ext;

    // Sensors are active low except the AM level.
    assign wheel   = ~i_wheel_raw;
    assign am      = i_am_raw;
    assign bit_one = ~i_bit_one_raw;
    assign bit_two = ~i_bit_two_raw;
    assign slot    = {1'b0, bit_two, bit_one}
                   + (wheel ? dpc_pkg::WHEEL_SLOT_STEP : '0)
                   + dpc_pkg::SLOT_BASE;

    assign is_clear = i_accept && (i_opcode == dpc_pkg::OP_CLEAR);
    assign is_tick  = i_accept && (i_opcode == dpc_pkg::OP_TICK);

    // Saturating increments.
    assign uptime_inc = (&r_uptime) ? r_uptime : r_uptime + 1'b1;
    assign quiet_inc  = (&r_quiet) ? r_quiet : r_quiet + 1'b1;
    assign count_inc  = (&r_move_count) ? r_move_count : r_move_count + 1'b1;

    assign past_holdoff  = 32'(uptime_inc) > 32'(i_cfg.startup_holdoff_ms);
    assign debounce_done = 32'(quiet_inc) > 32'(i_cfg.debounce_ms);
    assign quick_done    = 32'(quiet_inc) > 32'(i_cfg.quick_turn_ms);

    // Wheel is checked first, then AM, then the slot.
    assign wheel_diff = wheel != r_prev_wheel;
    assign am_diff    = am != r_prev_am;
    assign slot_diff  = slot != r_prev_slot;
    assign change     = past_holdoff && (wheel_diff || am_diff || slot_diff);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (is_clear) begin
            n_phase = dpc_pkg::PH_IDLE;
        end else if (is_tick) begin
            case (r_phase)
                dpc_pkg::PH_DEBOUNCE: begin
                    if (debounce_done) begin
                        n_phase = dpc_pkg::PH_COUNT;
                    end
                end
                dpc_pkg::PH_COUNT: begin
                    n_phase = dpc_pkg::PH_WAIT;
                end
                dpc_pkg::PH_WAIT: begin
                    if (quick_done) begin
                        n_phase = dpc_pkg::PH_DETECTED;
                    end else if (change) begin
                        n_phase = dpc_pkg::PH_DEBOUNCE;
                    end
                end
                dpc_pkg::PH_DETECTED: begin
                end
                default: begin
                    if (change) begin
                        n_phase = dpc_pkg::PH_DEBOUNCE;
                    end
                end
            endcase
        end
    end

    // Timers, count and reference readings.
    always_comb begin
        n_quiet      = r_quiet;
        n_uptime     = r_uptime;
        n_move_count = r_move_count;
        n_prev_slot  = r_prev_slot;
        n_prev_am    = r_prev_am;
        n_prev_wheel = r_prev_wheel;
        if (is_clear) begin
            n_move_count = COUNT_ZERO;
            n_prev_slot  = slot;
            n_prev_am    = am;
            n_prev_wheel = wheel;
        end else if (is_tick) begin
            n_uptime = uptime_inc;
            n_quiet  = quiet_inc;
            if (past_holdoff && wheel_diff) begin
                n_prev_wheel = wheel;
            end else if (past_holdoff && am_diff) begin
                n_prev_am = am;
            end
            case (r_phase)
                dpc_pkg::PH_DEBOUNCE: begin
                    if (debounce_done) begin
                        n_quiet      = TIMER_ZERO;
                        n_move_count = count_inc;
                    end else if (change) begin
                        n_quiet     = TIMER_ZERO;
                        n_prev_slot = slot;
                    end
                end
                dpc_pkg::PH_COUNT: begin
                    n_quiet     = TIMER_ZERO;
                    n_prev_slot = slot;
                end
                dpc_pkg::PH_WAIT: begin
                    if (!quick_done && change) begin
                        n_quiet = TIMER_ZERO;
                    end
                end
                dpc_pkg::PH_DETECTED: begin
                end
                default: begin
                    if (change) begin
                        n_quiet = TIMER_ZERO;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= dpc_pkg::PH_IDLE;
            r_quiet      <= TIMER_ZERO;
            r_uptime     <= TIMER_ZERO;
            r_move_count <= COUNT_ZERO;
            r_prev_slot  <= '0;
            r_prev_am    <= 1'b1;
            r_prev_wheel <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_quiet      <= n_quiet;
            r_uptime     <= n_uptime;
            r_move_count <= n_move_count;
            r_prev_slot  <= n_prev_slot;
            r_prev_am    <= n_prev_am;
            r_prev_wheel <= n_prev_wheel;
        end
    end

    // Result fields.
    assign count_ext = 32'(n_move_count);

    always_comb begin
        o_result.slot_index    = slot;
        o_result.is_am         = am;
        o_result.wheel_now     = wheel;
        o_result.detected      = (n_phase == dpc_pkg::PH_DETECTED);
        o_result.moves_counted = count_ext[dpc_pkg::MOVES_BITS-1:0];
        o_result.phase         = n_phase;
    end

    // A clear always lands in idle with an empty count.
    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_clear |=> (r_phase == dpc_pkg::PH_IDLE) && (r_move_count == COUNT_ZERO))
        else $error("clear did not reset phase and count");

    // Detection holds until a clear.
    a_detect_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dpc_pkg::PH_DETECTED) && !is_clear |=> (r_phase == dpc_pkg::PH_DETECTED))
        else $error("detected phase left without clear");

    // Apart from a clear, the count moves only on a debounce completion.
    a_count_only_on_debounce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !is_clear && !((r_phase == dpc_pkg::PH_DEBOUNCE) && (n_phase == dpc_pkg::PH_COUNT))
        |=> $stable(r_move_count))
        else $error("move count changed outside a debounce completion");

    // A tick in the count phase always advances it to waiting.
    a_count_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dpc_pkg::PH_COUNT) && is_tick |=> (r_phase == dpc_pkg::PH_WAIT))
        else $error("count phase did not advance to waiting");

endmodule

FILE: src/debounced_position_change_counter.sv
// ----------------------------------------------------------------------------
// debounced_position_change_counter
// Decodes hall-sensor readings into a slot, AM flag and wheel, debounces
// position changes and counts movements until a clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one word per millisecond tick or clear. tdata
//   carries the four raw sensor levels, tuser the opcode (tick or clear).
//   Output stream (m_axis): exactly one result word per input word, in
//   order, carrying the decoded readings, the detected flag, the movement
//   count and the phase after that word.
//   Config port: an index and 16-bit data, written when i_cfg_valid is high;
//   o_cfg_ready is always high. Writes belong to idle periods.
//   Output: o_m_axis_tdata shows the result in the cycle after acceptance.
//   Throughput: one word per cycle. All decode, compare and state update
//   work is one short step between the phase/timer registers and the output
//   register, so a new word can enter every cycle unless a result waits.
//   Stall: the output register holds its word while i_m_axis_tready is low;
//   o_s_axis_tready stays high when the output register is empty or is
//   being emptied in the same cycle, and drops only while a result waits.
//   Reset: synchronous, active low. The phase returns to idle, the count and
//   timers to zero, the references to slot zero, AM set and wheel zero, and
//   the config registers to 200, 1500 and 10000 ticks. No clearing pass.
// ----------------------------------------------------------------------------
module debounced_position_change_counter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input stream.
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata from bit 0: wheel_raw, am_raw, bit_one_raw, bit_two_raw, zeros.
    input  logic [dpc_pkg::S_TDATA_BITS-1:0]     i_s_axis_tdata,
    // tuser: opcode (0 tick, 1 clear).
    input  logic                                 i_s_axis_tuser,
    // Output stream.
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata from bit 0: slot_index[2:0], is_am, wheel_now, detected,
    // moves_counted[7:0], phase[2:0], zeros.
    output logic [dpc_pkg::M_TDATA_BITS-1:0]     o_m_axis_tdata,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dpc_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [dpc_pkg::CFG_BITS-1:0]         i_cfg_data
);

    dpc_pkg::t_cfg    cfg;
    dpc_pkg::t_result result;
    logic             s_accept;
    logic             r_m_valid;
    logic [dpc_pkg::M_TDATA_BITS-1:0] r_m_data, n_m_data;

    assign o_cfg_ready = 1'b1;

    dpc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // The output register frees up in the same cycle it is taken.
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    dpc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_opcode      (i_s_axis_tuser),
        .i_wheel_raw   (i_s_axis_tdata[0]),
        .i_am_raw      (i_s_axis_tdata[1]),
        .i_bit_one_raw (i_s_axis_tdata[2]),
        .i_bit_two_raw (i_s_axis_tdata[3]),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    // Pack the result with the first field in the lowest bits.
    assign n_m_data = {
        {(dpc_pkg::M_TDATA_BITS - dpc_pkg::M_TDATA_USED){1'b0}},
        result.phase,
        result.moves_counted,
        result.detected,
        result.wheel_now,
        result.is_am,
        result.slot_index
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

FILE: test/debounced_position_change_counter_tb.sv
// ----------------------------------------------------------------------------
// debounced_position_change_counter_tb
// Self-checking bench for the debounced position change counter. Sensor words
// are queued by phase, sent through the input stream with random gaps, and
// every readout word is compared field by field against a cycle-free model of
// the phase machine, the saturating timers and the movement count.
// ----------------------------------------------------------------------------
module debounced_position_change_counter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [dpc_pkg::CFG_IDX_BITS-1:0] REG_NONE = 2'd3;

    // Chance in a hundred that a side sits out a cycle.
    localparam int IDLE_PCT = 9;

    // One sensor word as it travels on the input stream. The raw nibble is
    // ordered as on tdata: wheel, AM, low position bit, high position bit.
    typedef struct {
        dpc_pkg::t_opcode op;
        logic [3:0]       raw;
    } t_sensor_word;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [dpc_pkg::S_TDATA_BITS-1:0] i_s_axis_tdata = '0;
    logic                             i_s_axis_tuser = 1'b0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [dpc_pkg::M_TDATA_BITS-1:0] o_m_axis_tdata;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [dpc_pkg::CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [dpc_pkg::CFG_BITS-1:0]     i_cfg_data = '0;

    debounced_position_change_counter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Words waiting to be sent, and readouts predicted for accepted words.
    t_sensor_word     sensor_words[$];
    dpc_pkg::t_result readouts_due[$];

    int words_accepted = 0;
    int readouts_seen = 0;
    int readout_errors = 0;

    // Model copy of the configuration registers.
    logic [dpc_pkg::CFG_BITS-1:0] debounce_thr = dpc_pkg::DEBOUNCE_RESET;
    logic [dpc_pkg::CFG_BITS-1:0] quick_thr = dpc_pkg::QUICK_TURN_RESET;
    logic [dpc_pkg::CFG_BITS-1:0] holdoff_thr = dpc_pkg::HOLDOFF_RESET;

    // Model copy of the tracker state, at its reset values.
    dpc_pkg::t_phase                ph = dpc_pkg::PH_IDLE;
    logic [dpc_pkg::COUNT_BITS-1:0] moves = '0;
    logic [dpc_pkg::SLOT_BITS-1:0]  ref_slot = '0;
    logic                           ref_am = 1'b1;
    logic                           ref_wheel = 1'b0;
    logic [dpc_pkg::TIMER_BITS-1:0] quiet = '0;
    logic [dpc_pkg::TIMER_BITS-1:0] uptime = '0;

    // The receiver's one long hold-off, counted down in cycles.
    int  hold_cycles = 0;
    bit  hold_done = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Advances the model by one accepted sensor word and returns the readout
    // that the block must produce for it.
    function automatic dpc_pkg::t_result predict_readout(dpc_pkg::t_opcode op,
                                                         logic [3:0] raw);
        logic                          wheel;
        logic                          am;
        logic [1:0]                    pos;
        logic [dpc_pkg::SLOT_BITS-1:0] slot;
        logic                          moved;
        dpc_pkg::t_result              r;
        wheel = ~raw[0];
        am    = raw[1];
        pos   = {~raw[3], ~raw[2]};
        slot  = dpc_pkg::SLOT_BITS'(pos) + (wheel ? dpc_pkg::WHEEL_SLOT_STEP : '0)
              + dpc_pkg::SLOT_BASE;
        moved = 1'b0;
        if (op == dpc_pkg::OP_CLEAR) begin
            // A clear takes the present readings as the new reference but
            // leaves both timers unchanged.
            moves     = '0;
            ph        = dpc_pkg::PH_IDLE;
            ref_slot  = slot;
            ref_am    = am;
            ref_wheel = wheel;
        end else begin
            if (uptime != '1) uptime = uptime + 1'b1;
            if (quiet != '1) quiet = quiet + 1'b1;
            // Change detection is off until the hold-off has passed. Wheel
            // and AM refresh their reference on a hit, the slot does not.
            if (uptime > holdoff_thr) begin
                if (wheel != ref_wheel) begin
                    ref_wheel = wheel;
                    moved = 1'b1;
                end else if (am != ref_am) begin
                    ref_am = am;
                    moved = 1'b1;
                end else begin
                    moved = (slot != ref_slot);
                end
            end
            case (ph)
                dpc_pkg::PH_DEBOUNCE: begin
                    if (quiet > debounce_thr) begin
                        quiet = '0;
                        if (moves != '1) moves = moves + 1'b1;
                        ph = dpc_pkg::PH_COUNT;
                    end else if (moved) begin
                        quiet = '0;
                        ref_slot = slot;
                    end
                end
                dpc_pkg::PH_COUNT: begin
                    ph = dpc_pkg::PH_WAIT;
                    quiet = '0;
                    ref_slot = slot;
                end
                dpc_pkg::PH_WAIT: begin
                    if (quiet > quick_thr) begin
                        ph = dpc_pkg::PH_DETECTED;
                    end else if (moved) begin
                        ph = dpc_pkg::PH_DEBOUNCE;
                        quiet = '0;
                    end
                end
                dpc_pkg::PH_DETECTED: begin
                end
                default: begin
                    if (moved) begin
                        ph = dpc_pkg::PH_DEBOUNCE;
                        quiet = '0;
                    end
                end
            endcase
        end
        r.slot_index    = slot;
        r.is_am         = am;
        r.wheel_now     = wheel;
        r.detected      = (ph == dpc_pkg::PH_DETECTED);
        r.moves_counted = dpc_pkg::MOVES_BITS'(moves);
        r.phase         = ph;
        return r;
    endfunction

    // Sender: presents the next queued word, or idles now and then. Outside
    // a window of accepted words it sits out about nine times in a hundred.
    always @(posedge i_clk) begin : drive_sensor_words
        t_sensor_word w;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                readouts_due.push_back(predict_readout(
                    dpc_pkg::t_opcode'(i_s_axis_tuser), i_s_axis_tdata[3:0]));
                words_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (sensor_words.size() > 0 &&
                    ((words_accepted >= 400 && words_accepted < 650) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    w = sensor_words.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {4'b0000, w.raw};
                    i_s_axis_tuser  <= w.op;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off: starts once after 200 readouts and holds
    // tready low until its countdown runs out, so the output register fills
    // and the input stream has to back off.
    always @(posedge i_clk) begin : receiver_hold
        if (!i_rst_n) begin
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && readouts_seen >= 200) begin
            hold_done   <= 1'b1;
            hold_cycles <= 80;
        end
    end

    // Receiver: checks each readout word against the oldest prediction and
    // stalls at random, or for as long as the hold-off runs.
    always @(posedge i_clk) begin : check_readouts
        dpc_pkg::t_result want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                readouts_seen++;
                if (readouts_due.size() == 0) begin
                    readout_errors++;
                    if (readout_errors <= 10)
                        $display("%0t: unexpected readout word %h", $realtime,
                                 o_m_axis_tdata);
                end else begin
                    want = readouts_due.pop_front();
                    if (o_m_axis_tdata[2:0]   !== want.slot_index ||
                        o_m_axis_tdata[3]     !== want.is_am ||
                        o_m_axis_tdata[4]     !== want.wheel_now ||
                        o_m_axis_tdata[5]     !== want.detected ||
                        o_m_axis_tdata[13:6]  !== want.moves_counted ||
                        o_m_axis_tdata[16:14] !== want.phase) begin
                        readout_errors++;
                        if (readout_errors <= 10)
                            $display({"%0t: readout %0d mismatch: slot %0d/%0d am %b/%b ",
                                      "wheel %b/%b det %b/%b moves %0d/%0d phase %0d/%0d ",
                                      "(expected/actual)"},
                                     $realtime, readouts_seen,
                                     want.slot_index, o_m_axis_tdata[2:0],
                                     want.is_am, o_m_axis_tdata[3],
                                     want.wheel_now, o_m_axis_tdata[4],
                                     want.detected, o_m_axis_tdata[5],
                                     want.moves_counted, o_m_axis_tdata[13:6],
                                     want.phase, o_m_axis_tdata[16:14]);
                    end
                end
            end
            if (hold_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= (readouts_seen >= 400 && readouts_seen < 650) ||
                                   ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic queue_word(dpc_pkg::t_opcode op, logic [3:0] raw);
        t_sensor_word w;
        w.op  = op;
        w.raw = raw;
        sensor_words.push_back(w);
    endtask

    task automatic queue_ticks(logic [3:0] raw, int n);
        repeat (n) queue_word(dpc_pkg::OP_TICK, raw);
    endtask

    // Queues about n words of plausible sensor traffic: a reading held long
    // enough to settle, contact bounce, the odd clear and a little noise.
    task automatic queue_movements(int n, int hold_max);
        int   added;
        int   pick;
        int   k;
        logic [3:0] raw;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                queue_word(dpc_pkg::OP_CLEAR, 4'($urandom));
                added += 1;
            end else if (pick < 20) begin
                queue_word(dpc_pkg::t_opcode'($urandom_range(1)), 4'($urandom));
                added += 1;
            end else if (pick < 30) begin
                k = $urandom_range(2, 5);
                repeat (k) queue_word(dpc_pkg::OP_TICK, 4'($urandom));
                added += k;
            end else begin
                raw = 4'($urandom);
                k = $urandom_range(1, hold_max);
                queue_ticks(raw, k);
                added += k;
            end
        end
    endtask

    // Writes one register while the block is idle and mirrors it in the model.
    task automatic write_register(logic [dpc_pkg::CFG_IDX_BITS-1:0] idx,
                                  logic [dpc_pkg::CFG_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            dpc_pkg::REG_DEBOUNCE:   debounce_thr = value;
            dpc_pkg::REG_QUICK_TURN: quick_thr = value;
            dpc_pkg::REG_HOLDOFF:    holdoff_thr = value;
            default: begin
            end
        endcase
    endtask

    task automatic write_thresholds(logic [dpc_pkg::CFG_BITS-1:0] deb,
                                    logic [dpc_pkg::CFG_BITS-1:0] quick,
                                    logic [dpc_pkg::CFG_BITS-1:0] hold);
        write_register(dpc_pkg::REG_DEBOUNCE, deb);
        write_register(dpc_pkg::REG_QUICK_TURN, quick);
        write_register(dpc_pkg::REG_HOLDOFF, hold);
    endtask

    // Waits until every queued word is accepted and every readout is back,
    // plus a short margin for the output register.
    task automatic wait_drained();
        while (sensor_words.size() != 0 || i_s_axis_tvalid || readouts_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [3:0] raw;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds: the hold-off is far away, so every sensor
        // combination just decodes. Covers slots 1 through 7 and both flags.
        for (int i = 0; i < 16; i++) queue_word(dpc_pkg::OP_TICK, 4'(i));
        queue_word(dpc_pkg::OP_CLEAR, 4'b0000);
        queue_word(dpc_pkg::OP_CLEAR, 4'b1111);
        wait_drained();

        // All thresholds at zero: one change walks the machine through
        // debouncing, counting, waiting and detected, then a clear returns
        // it to idle. The unused index must not disturb anything.
        write_thresholds('0, '0, '0);
        write_register(REG_NONE, dpc_pkg::CFG_BITS'($urandom));
        queue_word(dpc_pkg::OP_CLEAR, 4'b1111);
        queue_ticks(4'b1111, 1);
        queue_ticks(4'b0000, 4);
        queue_ticks(4'b0101, 1);
        queue_word(dpc_pkg::OP_CLEAR, 4'b0101);
        wait_drained();

        // Short thresholds with settled readings and bounce.
        write_thresholds(dpc_pkg::CFG_BITS'($urandom_range(1, 6)),
                         dpc_pkg::CFG_BITS'($urandom_range(4, 15)), '0);
        queue_movements(150, 14);
        wait_drained();

        // Count saturation: a new reading every three ticks adds one move
        // each time, and the waiting phase never times out.
        write_thresholds('0, '1, '0);
        raw = 4'($urandom);
        queue_word(dpc_pkg::OP_CLEAR, raw);
        repeat (262) begin
            raw = raw ^ 4'($urandom_range(1, 15));
            queue_ticks(raw, 3);
        end
        wait_drained();

        // Zero thresholds with random traffic.
        write_register(dpc_pkg::REG_QUICK_TURN, '0);
        queue_movements(100, 4);
        wait_drained();

        // A full-scale hold-off can never be passed by the saturating uptime,
        // so change detection stays off.
        write_thresholds(16'd2, 16'd5, '1);
        queue_movements(80, 8);
        wait_drained();

        // Moderate thresholds and a long run of movement traffic.
        write_thresholds(dpc_pkg::CFG_BITS'($urandom_range(0, 8)),
                         dpc_pkg::CFG_BITS'($urandom_range(0, 20)), 16'd100);
        queue_movements(250, 25);
        wait_drained();

        if (readout_errors == 0) begin
            $display("PASS debounced_position_change_counter");
        end else begin
            $display("FAIL debounced_position_change_counter");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest correct run.
    initial begin : watchdog
        #200_000;
        $display("FAIL debounced_position_change_counter");
        $finish;
    end

endmodule

FILE: sim.f
src/dpc_pkg.sv
src/dpc_cfg_regs.sv
src/dpc_core.sv
src/debounced_position_change_counter.sv
test/debounced_position_change_counter_tb.sv
